// File: hw/rtl/mbps_pkg.sv
// Shared types, register indexes and defaults for the masked byte pattern scanner.
package mbps_pkg;

   localparam int MAX_PATTERN_BYTES_DEF = 16;
   localparam int OFFSET_BITS_DEF       = 32;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOW  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HIGH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CARE_MASK    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LEN  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPORT_ALL   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_BASE  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESULT_ADJ   = 3'd6;

   typedef struct packed {
      logic [63:0] pattern_low;
      logic [63:0] pattern_high;
      logic [15:0] care_mask;
      logic [4:0]  pattern_length;
      logic        report_all;
      logic [63:0] region_base;
      logic [31:0] result_adjust;
   } cfg_type;

   // Status that travels from the match stage to the response stage.
   typedef struct packed {
      logic        hit;
      logic        last;
      logic        found;
      logic [15:0] count;
   } mid_type;

endpackage

// File: hw/rtl/mbps_csr.sv
// Configuration register file of the pattern scanner.
module mbps_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mbps_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mbps_pkg::CSR_DATA_W-1:0]    csr_data,
   output mbps_pkg::cfg_type                  cfg
);

   mbps_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            mbps_pkg::CSR_PATTERN_LOW:  cfg_in.pattern_low    = csr_data;
            mbps_pkg::CSR_PATTERN_HIGH: cfg_in.pattern_high   = csr_data;
            mbps_pkg::CSR_CARE_MASK:    cfg_in.care_mask      = csr_data[15:0];
            mbps_pkg::CSR_PATTERN_LEN:  cfg_in.pattern_length = csr_data[4:0];
            mbps_pkg::CSR_REPORT_ALL:   cfg_in.report_all     = csr_data[0];
            mbps_pkg::CSR_REGION_BASE:  cfg_in.region_base    = csr_data;
            mbps_pkg::CSR_RESULT_ADJ:   cfg_in.result_adjust  = csr_data[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_low    <= '0;
         cfg_ff.pattern_high   <= '0;
         cfg_ff.care_mask      <= 16'hFFFF;
         cfg_ff.pattern_length <= 5'd1;
         cfg_ff.report_all     <= 1'b0;
         cfg_ff.region_base    <= '0;
         cfg_ff.result_adjust  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hw/rtl/mbps_match.sv
// Byte window, region counters and parallel masked compare, with the match stage register.
module mbps_match #(
   parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF,
   parameter int OFFSET_BITS       = mbps_pkg::OFFSET_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mbps_pkg::cfg_type       cfg,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_byte,
   input  logic                    req_last,
   input  logic                    mid_ready,
   output logic                    mid_valid,
   output mbps_pkg::mid_type       mid_info,
   output logic [OFFSET_BITS-1:0]  mid_offset
);

   localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

   logic [7:0]             window_ff [MAX_PATTERN_BYTES];
   logic [7:0]             window_in [MAX_PATTERN_BYTES];
   logic [OFFSET_BITS-1:0] seen_ff, seen_in;
   logic                   found_ff, found_in;
   logic [15:0]            hits_ff, hits_in;

   logic                   mid_valid_ff, mid_valid_in;
   mbps_pkg::mid_type      mid_info_ff, mid_info_in;
   logic [OFFSET_BITS-1:0] mid_offset_ff, mid_offset_in;

   logic                   accept;
   logic [5:0]             len6;
   logic [LEN_W-1:0]       len_eff;
   logic [MAX_PATTERN_BYTES-1:0] miss;
   logic                   match;
   logic [OFFSET_BITS-1:0] seen_next;
   logic [15:0]            hits_next;
   logic                   found_next;
   logic                   report;

   assign req_tready = !mid_valid_ff || mid_ready;
   assign accept     = req_tvalid && req_tready;
   assign mid_valid  = mid_valid_ff;
   assign mid_info   = mid_info_ff;
   assign mid_offset = mid_offset_ff;

   // Pattern length zero counts as one; anything above the window depth is clamped.
   always_comb begin
      if (cfg.pattern_length == 5'd0) begin
         len6 = 6'd1;
      end else if ({1'b0, cfg.pattern_length} > 6'(MAX_PATTERN_BYTES)) begin
         len6 = 6'(MAX_PATTERN_BYTES);
      end else begin
         len6 = {1'b0, cfg.pattern_length};
      end
      len_eff = LEN_W'(len6);
   end

   // The window as it stands once the new byte has shifted in; entry 0 is the newest.
   always_comb begin
      window_in[0] = req_byte;
      for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
         window_in[k] = window_ff[k-1];
      end
   end

   assign seen_next = (seen_ff == '1) ? seen_ff : seen_ff + 1'b1;

   // Pattern byte i lines up with window entry len-1-i.
   for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cmp
      logic [7:0]       want;
      logic             care;
      logic [IDX_W-1:0] sel;
      if (i < 8) begin : g_low
         assign want = cfg.pattern_low[8*i +: 8];
         assign care = cfg.care_mask[i];
      end else if (i < 16) begin : g_high
         assign want = cfg.pattern_high[8*(i-8) +: 8];
         assign care = cfg.care_mask[i];
      end else begin : g_none
         assign want = 8'd0;
         assign care = 1'b0;
      end
      assign sel     = IDX_W'(int'(len_eff) - 1 - i);
      assign miss[i] = care && (LEN_W'(i) < len_eff) && (window_in[sel] != want);
   end

   assign match      = (seen_next >= OFFSET_BITS'(len_eff)) && !(|miss);
   assign found_next = found_ff || match;
   assign hits_next  = (match && hits_ff != '1) ? hits_ff + 1'b1 : hits_ff;
   assign report     = match && (!found_ff || cfg.report_all);

   always_comb begin
      seen_in  = seen_ff;
      found_in = found_ff;
      hits_in  = hits_ff;
      mid_info_in   = mid_info_ff;
      mid_offset_in = mid_offset_ff;
      if (mid_ready) begin
         mid_valid_in = 1'b0;
      end else begin
         mid_valid_in = mid_valid_ff;
      end
      if (accept) begin
         mid_valid_in       = 1'b1;
         mid_info_in.hit    = report;
         mid_info_in.last   = req_last;
         mid_info_in.found  = found_next;
         mid_info_in.count  = hits_next;
         mid_offset_in      = report ? seen_next - OFFSET_BITS'(len_eff) : '0;
         if (req_last) begin
            seen_in  = '0;
            found_in = 1'b0;
            hits_in  = '0;
         end else begin
            seen_in  = seen_next;
            found_in = found_next;
            hits_in  = hits_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            window_ff[k] <= '0;
         end
      end else if (accept) begin
         for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            window_ff[k] <= req_last ? 8'd0 : window_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= '0;
         found_ff     <= 1'b0;
         hits_ff      <= '0;
         mid_valid_ff <= 1'b0;
      end else begin
         seen_ff      <= seen_in;
         found_ff     <= found_in;
         hits_ff      <= hits_in;
         mid_valid_ff <= mid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mid_info_ff   <= mid_info_in;
      mid_offset_ff <= mid_offset_in;
   end

endmodule

// File: hw/rtl/mbps_resp.sv
// Address computation and the response register; drops requests that carry no result.
module mbps_resp #(
   parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mbps_pkg::cfg_type       cfg,
   input  logic                    mid_valid,
   output logic                    mid_ready,
   input  mbps_pkg::mid_type       mid_info,
   input  logic [OFFSET_BITS-1:0]  mid_offset,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [119:0]            rsp_tdata,
   output logic                    rsp_tuser,
   output logic                    rsp_tlast
);

   localparam int OFS_EXT_W = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

   logic                 valid_ff, valid_in;
   logic                 hit_ff, hit_in;
   logic                 last_ff, last_in;
   logic                 found_ff, found_in;
   logic [15:0]          count_ff, count_in;
   logic [31:0]          offset_ff, offset_in;
   logic [63:0]          address_ff, address_in;
   logic [OFS_EXT_W-1:0] offset_ext;
   logic [63:0]          adjust_ext;
   logic                 take;

   assign mid_ready  = !valid_ff || rsp_tready;
   assign take       = mid_valid && mid_ready;
   assign offset_ext = OFS_EXT_W'(mid_offset);
   assign adjust_ext = {{32{cfg.result_adjust[31]}}, cfg.result_adjust};

   always_comb begin
      valid_in   = rsp_tready ? 1'b0 : valid_ff;
      hit_in     = hit_ff;
      last_in    = last_ff;
      found_in   = found_ff;
      count_in   = count_ff;
      offset_in  = offset_ff;
      address_in = address_ff;
      if (take) begin
         // Only a hit or the end of a region produces a response.
         valid_in   = mid_info.hit || mid_info.last;
         hit_in     = mid_info.hit;
         last_in    = mid_info.last;
         found_in   = mid_info.found;
         count_in   = mid_info.count;
         offset_in  = offset_ext[31:0];
         address_in = mid_info.hit ?
                      cfg.region_base + 64'(mid_offset) + adjust_ext : 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff     <= hit_in;
      last_ff    <= last_in;
      found_ff   <= found_in;
      count_ff   <= count_in;
      offset_ff  <= offset_in;
      address_ff <= address_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = hit_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {7'd0, count_ff, found_ff, address_ff, offset_ff};

endmodule

// File: hw/rtl/masked_byte_pattern_scanner_unit.sv
// Top level of the masked byte pattern scanner.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tdata: data_byte; tlast: region_last
//   rsp      out        rsp_tvalid/rsp_tready  tdata/tuser/tlast: match report or region end
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One request is taken every cycle while the match stage is free; the response for a
// request is registered in the match stage, then in the address add stage.
// Requests that neither hit nor end a region produce no response.
// Synchronous reset clears configuration to its defaults and empties the window.
// A stalled response holds its register; the match stage keeps accepting while it is free.
module masked_byte_pattern_scanner_unit #(
   parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF,
   parameter int OFFSET_BITS       = mbps_pkg::OFFSET_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [7:0] data_byte
   input  logic                              req_tlast,  // region_last
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] hit_offset, [95:32] hit_address, [96] found_any, [112:97] match_count
   output logic [119:0]                      rsp_tdata,
   output logic                              rsp_tuser,  // hit
   output logic                              rsp_tlast,  // region_done
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mbps_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mbps_pkg::CSR_DATA_W-1:0]   csr_data
);

   mbps_pkg::cfg_type      cfg;
   logic                   mid_valid;
   logic                   mid_ready;
   mbps_pkg::mid_type      mid_info;
   logic [OFFSET_BITS-1:0] mid_offset;

   mbps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mbps_match #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
      .OFFSET_BITS       (OFFSET_BITS)
   ) u_match (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_byte   (req_tdata),
      .req_last   (req_tlast),
      .mid_ready  (mid_ready),
      .mid_valid  (mid_valid),
      .mid_info   (mid_info),
      .mid_offset (mid_offset)
   );

   mbps_resp #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_resp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .mid_valid  (mid_valid),
      .mid_ready  (mid_ready),
      .mid_info   (mid_info),
      .mid_offset (mid_offset),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
